### rtl/mth_pkg.sv
// Shared types, constants and helper functions for the modulated tape sensor.
// Used by the configuration register block, the top level and the port checker.
// Depends on nothing else.
package mth_pkg;

  // Field widths of the sample and counter datapath.
  localparam int SAMPLE_BITS    = 10;
  localparam int COUNT_BITS     = 16;
  localparam int OUT_COUNT_BITS = 16;
  localparam int THR_BITS       = 10;

  // Signed compare width wide enough for a sample difference and a threshold.
  localparam int CMP_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;

  // APB register map: one 32-bit register every four bytes.
  localparam int PADDR_BITS = 5;
  localparam int PDATA_BITS = 32;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_LOW  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_HIGH = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CORNER_LOW  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_CORNER_HIGH = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_DARK_GATE   = 3'd4;

  // Register reset values.
  localparam logic [THR_BITS-1:0] CENTER_LOW_RESET  = 10'd350;
  localparam logic [THR_BITS-1:0] CENTER_HIGH_RESET = 10'd400;
  localparam logic [THR_BITS-1:0] CORNER_LOW_RESET  = 10'd450;
  localparam logic [THR_BITS-1:0] CORNER_HIGH_RESET = 10'd650;
  localparam logic [THR_BITS-1:0] DARK_GATE_RESET   = 10'd300;

  // Opcode of an input beat.
  localparam logic OP_LIT  = 1'b0;
  localparam logic OP_DARK = 1'b1;

  // Event kinds.
  localparam logic EV_ALL_WHITE = 1'b0;
  localparam logic EV_TAPE_ON   = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] center_sample;
    logic [SAMPLE_BITS-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic                      event_valid;
    logic                      event_kind;
    logic [2:0]                tape_mask;
    logic                      led_drive;
    logic [OUT_COUNT_BITS-1:0] lit_error_count;
    logic [OUT_COUNT_BITS-1:0] dark_error_count;
  } out_t;

  // Threshold set handed from the register block to the datapath.
  typedef struct packed {
    logic [THR_BITS-1:0] center_low;
    logic [THR_BITS-1:0] center_high;
    logic [THR_BITS-1:0] corner_low;
    logic [THR_BITS-1:0] corner_high;
    logic [THR_BITS-1:0] dark_gate;
  } cfg_t;

  // Hysteresis on one sensor: white turns black below low, black turns
  // white above high, otherwise the bit is kept.
  function automatic logic hyst_bit(input logic black,
                                    input logic signed [CMP_BITS-1:0] diff,
                                    input logic [THR_BITS-1:0] lo,
                                    input logic [THR_BITS-1:0] hi);
    logic signed [CMP_BITS-1:0] lo_s;
    logic signed [CMP_BITS-1:0] hi_s;
    logic                       res;
    lo_s = $signed(CMP_BITS'(lo));
    hi_s = $signed(CMP_BITS'(hi));
    res  = black;
    if (!black && (diff < lo_s)) begin
      res = 1'b1;
    end else if (black && (diff > hi_s)) begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

### rtl/mth_cfg.sv
// APB register block holding the five detection thresholds.
// Depends on mth_pkg for the register map, reset values and cfg_t.
module mth_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mth_pkg::PADDR_BITS-1:0] paddr,
  input  logic [mth_pkg::PDATA_BITS-1:0] pwdata,
  output logic [mth_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  output mth_pkg::cfg_t                  cfg
);
  import mth_pkg::*;

  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;
  logic [THR_BITS-1:0]     wr_val;

  assign reg_idx = paddr[PADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign wr_val  = pwdata[THR_BITS-1:0];
  assign pready  = 1'b1;

  // Register writes happen in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_low  <= CENTER_LOW_RESET;
      cfg.center_high <= CENTER_HIGH_RESET;
      cfg.corner_low  <= CORNER_LOW_RESET;
      cfg.corner_high <= CORNER_HIGH_RESET;
      cfg.dark_gate   <= DARK_GATE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER_LOW:  cfg.center_low  <= wr_val;
        REG_CENTER_HIGH: cfg.center_high <= wr_val;
        REG_CORNER_LOW:  cfg.corner_low  <= wr_val;
        REG_CORNER_HIGH: cfg.corner_high <= wr_val;
        REG_DARK_GATE:   cfg.dark_gate   <= wr_val;
        default: ;
      endcase
    end
  end

  // Read mux; unmapped addresses read as zero.
  always_comb begin
    case (reg_idx)
      REG_CENTER_LOW:  prdata = PDATA_BITS'(cfg.center_low);
      REG_CENTER_HIGH: prdata = PDATA_BITS'(cfg.center_high);
      REG_CORNER_LOW:  prdata = PDATA_BITS'(cfg.corner_low);
      REG_CORNER_HIGH: prdata = PDATA_BITS'(cfg.corner_high);
      REG_DARK_GATE:   prdata = PDATA_BITS'(cfg.dark_gate);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/modulated_tape_sensor_hysteresis.sv
// An accepted beat is held in the input register, then its result in the result
// register. One input beat per cycle unless the result register stalls; the input
// register feeds one short compute stage that updates the tape state and the result.
// Reset (rst, synchronous): both stages empty, stored lit readings, tape state
// and error counters cleared, LED on, thresholds back to their default values.
// Depends on mth_pkg and mth_cfg.
module modulated_tape_sensor_hysteresis (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mth_pkg::PADDR_BITS-1:0] paddr,
  input  logic [mth_pkg::PDATA_BITS-1:0] pwdata,
  output logic [mth_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mth_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mth_pkg::out_t                  out_data
);
  import mth_pkg::*;

  cfg_t cfg;

  // Input stage.
  logic s1_valid;
  in_t  s1_data;

  // Sensor state.
  logic [SAMPLE_BITS-1:0] lit_left;
  logic [SAMPLE_BITS-1:0] lit_center;
  logic [SAMPLE_BITS-1:0] lit_right;
  logic [2:0]             tape_bits;
  logic [COUNT_BITS-1:0]  lit_errors;
  logic [COUNT_BITS-1:0]  dark_errors;
  logic                   led_state;

  // Compute stage signals.
  logic                       s2_load;
  logic                       is_dark;
  logic                       zero_seen;
  logic signed [CMP_BITS-1:0] diff_left;
  logic signed [CMP_BITS-1:0] diff_center;
  logic signed [CMP_BITS-1:0] diff_right;
  logic                       gate_ok;
  logic [2:0]                 tape_bits_next;
  logic                       changed;
  logic [COUNT_BITS-1:0]      lit_errors_next;
  logic [COUNT_BITS-1:0]      dark_errors_next;
  logic                       led_state_next;
  out_t                       out_next;

  mth_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the compute stage moves when the result register is free or drains.
  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Differences, gate and hysteresis for the beat in the input register.
  always_comb begin
    is_dark   = (s1_data.opcode == OP_DARK);
    zero_seen = (s1_data.left_sample == '0) || (s1_data.center_sample == '0) ||
                (s1_data.right_sample == '0);
    diff_left   = $signed(CMP_BITS'(s1_data.left_sample)) -
                  $signed(CMP_BITS'(lit_left));
    diff_center = $signed(CMP_BITS'(s1_data.center_sample)) -
                  $signed(CMP_BITS'(lit_center));
    diff_right  = $signed(CMP_BITS'(s1_data.right_sample)) -
                  $signed(CMP_BITS'(lit_right));
    gate_ok = is_dark &&
              (CMP_BITS'(s1_data.center_sample) > CMP_BITS'(cfg.dark_gate)) &&
              (lit_center != '0) && (diff_center > $signed(CMP_BITS'(0)));

    tape_bits_next = tape_bits;
    if (gate_ok) begin
      tape_bits_next[0] = hyst_bit(tape_bits[0], diff_left,
                                   cfg.corner_low, cfg.corner_high);
      tape_bits_next[1] = hyst_bit(tape_bits[1], diff_center,
                                   cfg.center_low, cfg.center_high);
      tape_bits_next[2] = hyst_bit(tape_bits[2], diff_right,
                                   cfg.corner_low, cfg.corner_high);
    end
    changed = gate_ok && (tape_bits_next != tape_bits);
  end

  // Saturating error counters and LED.
  always_comb begin
    lit_errors_next  = lit_errors;
    dark_errors_next = dark_errors;
    if (zero_seen && !is_dark && (lit_errors != '1)) begin
      lit_errors_next = lit_errors + COUNT_BITS'(1);
    end
    if (zero_seen && is_dark && (dark_errors != '1)) begin
      dark_errors_next = dark_errors + COUNT_BITS'(1);
    end
    led_state_next = is_dark;
  end

  // Result beat.
  always_comb begin
    out_next.event_valid      = changed;
    out_next.event_kind       = (changed && (tape_bits_next != '0)) ? EV_TAPE_ON
                                                                    : EV_ALL_WHITE;
    out_next.tape_mask        = changed ? tape_bits_next : 3'b000;
    out_next.led_drive        = led_state_next;
    out_next.lit_error_count  = OUT_COUNT_BITS'(lit_errors_next);
    out_next.dark_error_count = OUT_COUNT_BITS'(dark_errors_next);
  end

  // State update as each beat leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_left    <= '0;
      lit_center  <= '0;
      lit_right   <= '0;
      tape_bits   <= '0;
      lit_errors  <= '0;
      dark_errors <= '0;
      led_state   <= 1'b1;
    end else if (s2_load) begin
      if (!is_dark) begin
        lit_left   <= s1_data.left_sample;
        lit_center <= s1_data.center_sample;
        lit_right  <= s1_data.right_sample;
      end
      tape_bits   <= tape_bits_next;
      lit_errors  <= lit_errors_next;
      dark_errors <= dark_errors_next;
      led_state   <= led_state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data <= out_next;
    end
  end

endmodule

### rtl/mth_checker.sv
// Port-level checker for the modulated tape sensor, bound to the top level.
// Depends on mth_pkg and on modulated_tape_sensor_hysteresis.
module mth_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input mth_pkg::out_t out_data
);
  import mth_pkg::*;

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An event only comes from a dark beat, and its kind matches the mask.
  a_event_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_valid |->
      out_data.led_drive &&
      (out_data.event_kind == (out_data.tape_mask != 3'b000)))
    else $error("event kind, mask or LED inconsistent");

  // Without an event, kind and mask are zero.
  a_no_event_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |->
      (out_data.event_kind == EV_ALL_WHITE) && (out_data.tape_mask == 3'b000))
    else $error("event fields set without an event");

endmodule

bind modulated_tape_sensor_hysteresis mth_checker u_mth_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/modulated_tape_sensor_hysteresis_tb.sv
// Self-checking testbench for modulated_tape_sensor_hysteresis: lit/dark beats in,
// one result beat out per input, thresholds written over the APB-style port.
// Depends on mth_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module modulated_tape_sensor_hysteresis_tb;
  import mth_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;

  modulated_tape_sensor_hysteresis uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Sensor state as the block should hold it, with its own copy of the thresholds.
  cfg_t                  sensor_cfg;
  logic [SAMPLE_BITS-1:0] stored_left;
  logic [SAMPLE_BITS-1:0] stored_center;
  logic [SAMPLE_BITS-1:0] stored_right;
  logic [2:0]            tape_state;
  logic [COUNT_BITS-1:0] lit_zero_count;
  logic [COUNT_BITS-1:0] dark_zero_count;
  logic                  led_on;

  out_t expected_results[$];
  int   mismatch_count = 0;

  // Traffic shaping; idle_en for sender and receiver, the counts for the receiver.
  bit idle_en   = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  // One sensor bit: white goes black below low, black goes white above high.
  function automatic logic hyst_next(logic black, int diff, logic [THR_BITS-1:0] lo,
                                     logic [THR_BITS-1:0] hi);
    if (!black && diff < int'(lo)) return 1'b1;
    if (black && diff > int'(hi)) return 1'b0;
    return black;
  endfunction

  // Advances the sensor state by one beat and returns the result it causes.
  function automatic out_t predict_reading(in_t beat);
    out_t       res;
    logic       any_zero;
    int         dl;
    int         dc;
    int         dr;
    logic [2:0] nb;
    res = '0;
    any_zero = (beat.left_sample == 0) || (beat.center_sample == 0) ||
               (beat.right_sample == 0);
    if (beat.opcode == OP_LIT) begin
      stored_left   = beat.left_sample;
      stored_center = beat.center_sample;
      stored_right  = beat.right_sample;
      if (any_zero && lit_zero_count != '1)
        lit_zero_count = lit_zero_count + COUNT_BITS'(1);
      led_on = 1'b0;
    end else begin
      dl = int'(beat.left_sample) - int'(stored_left);
      dc = int'(beat.center_sample) - int'(stored_center);
      dr = int'(beat.right_sample) - int'(stored_right);
      if (any_zero && dark_zero_count != '1)
        dark_zero_count = dark_zero_count + COUNT_BITS'(1);
      if (beat.center_sample > sensor_cfg.dark_gate && stored_center != 0 && dc > 0) begin
        nb[0] = hyst_next(tape_state[0], dl, sensor_cfg.corner_low, sensor_cfg.corner_high);
        nb[1] = hyst_next(tape_state[1], dc, sensor_cfg.center_low, sensor_cfg.center_high);
        nb[2] = hyst_next(tape_state[2], dr, sensor_cfg.corner_low, sensor_cfg.corner_high);
        if (nb != tape_state) begin
          res.event_valid = 1'b1;
          res.event_kind  = (nb != 3'b000) ? EV_TAPE_ON : EV_ALL_WHITE;
          res.tape_mask   = nb;
        end
        tape_state = nb;
      end
      led_on = 1'b1;
    end
    res.led_drive        = led_on;
    res.lit_error_count  = OUT_COUNT_BITS'(lit_zero_count);
    res.dark_error_count = OUT_COUNT_BITS'(dark_zero_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Result beats are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 32'(out_data), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.event_valid !== want.event_valid)
            report_mismatch("event_valid", 32'(out_data.event_valid),
                            32'(want.event_valid));
          if (out_data.event_kind !== want.event_kind)
            report_mismatch("event_kind", 32'(out_data.event_kind),
                            32'(want.event_kind));
          if (out_data.tape_mask !== want.tape_mask)
            report_mismatch("tape_mask", 32'(out_data.tape_mask), 32'(want.tape_mask));
          if (out_data.led_drive !== want.led_drive)
            report_mismatch("led_drive", 32'(out_data.led_drive), 32'(want.led_drive));
          if (out_data.lit_error_count !== want.lit_error_count)
            report_mismatch("lit_error_count", 32'(out_data.lit_error_count),
                            32'(want.lit_error_count));
          if (out_data.dark_error_count !== want.dark_error_count)
            report_mismatch("dark_error_count", 32'(out_data.dark_error_count),
                            32'(want.dark_error_count));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_reading(in_data));
    end
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int roll;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!idle_en) begin
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          out_ready <= 1'b1;
        end else if (roll < 95) begin
          out_ready <= 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (!idle_en) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t make_beat(logic op, int l, int c, int r);
    in_t b;
    b.opcode        = op;
    b.left_sample   = SAMPLE_BITS'(l);
    b.center_sample = SAMPLE_BITS'(c);
    b.right_sample  = SAMPLE_BITS'(r);
    return b;
  endfunction

  // Offers one beat after an optional gap and returns once it is accepted.
  task automatic send_beat(input in_t beat);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_BITS-1:0] idx,
                                input logic [THR_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Upper bits carry junk; only the low threshold bits are kept.
    pwdata  <= {22'($urandom_range(0, 4194303)), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_LOW:  sensor_cfg.center_low  = value;
      REG_CENTER_HIGH: sensor_cfg.center_high = value;
      REG_CORNER_LOW:  sensor_cfg.corner_low  = value;
      REG_CORNER_HIGH: sensor_cfg.corner_high = value;
      REG_DARK_GATE:   sensor_cfg.dark_gate   = value;
      default: ;
    endcase
  endtask

  task automatic write_thresholds(input int cl, input int ch, input int kl, input int kh,
                                  input int gate);
    write_register(REG_CENTER_LOW, THR_BITS'(cl));
    write_register(REG_CENTER_HIGH, THR_BITS'(ch));
    write_register(REG_CORNER_LOW, THR_BITS'(kl));
    write_register(REG_CORNER_HIGH, THR_BITS'(kh));
    write_register(REG_DARK_GATE, THR_BITS'(gate));
  endtask

  function automatic int pick_threshold();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 0;
    if (roll < 30) return 1023;
    if (roll < 70) return $urandom_range(200, 700);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_lit_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 10) return 1023;
    if (roll < 70) return $urandom_range(0, 400);
    return $urandom_range(0, 1023);
  endfunction

  // Dark minus lit, aimed mostly at the hysteresis edges.
  function automatic int pick_delta(logic [THR_BITS-1:0] lo, logic [THR_BITS-1:0] hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return int'(lo) + int'($urandom_range(0, 8)) - 4;
    if (roll < 80) return int'(hi) + int'($urandom_range(0, 8)) - 4;
    if (roll < 90) return -int'($urandom_range(0, 1023));
    return $urandom_range(0, 1023);
  endfunction

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // A well-formed lit/dark pair with random content.
  task automatic send_reading_pair();
    int ll;
    int lc;
    int lr;
    ll = pick_lit_sample();
    lc = pick_lit_sample();
    lr = pick_lit_sample();
    send_beat(make_beat(OP_LIT, ll, lc, lr));
    send_beat(make_beat(OP_DARK,
      clamp_sample(ll + pick_delta(sensor_cfg.corner_low, sensor_cfg.corner_high)),
      clamp_sample(lc + pick_delta(sensor_cfg.center_low, sensor_cfg.center_high)),
      clamp_sample(lr + pick_delta(sensor_cfg.corner_low, sensor_cfg.corner_high))));
  endtask

  task automatic send_noise_beat();
    send_beat(make_beat(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023)));
  endtask

  // Edge cases at the reset thresholds: gate, zero readings, order, equality.
  task automatic test_directed_cases();
    idle_en = 1'b1;
    // Dark before any lit: stored center is zero, so no update.
    send_beat(make_beat(OP_DARK, 1023, 1023, 1023));
    send_beat(make_beat(OP_LIT, 0, 0, 0));
    send_beat(make_beat(OP_DARK, 0, 0, 0));
    // Two lit beats in a row, then a zero center difference.
    send_beat(make_beat(OP_LIT, 1023, 1023, 1023));
    send_beat(make_beat(OP_LIT, 1023, 1023, 1023));
    send_beat(make_beat(OP_DARK, 1023, 1023, 1023));
    // Left and center go black, right stays white; repeat gives no event.
    send_beat(make_beat(OP_LIT, 100, 100, 100));
    send_beat(make_beat(OP_DARK, 200, 400, 900));
    send_beat(make_beat(OP_DARK, 200, 400, 900));
    // Back to all white, with a zero lit reading on the left.
    send_beat(make_beat(OP_LIT, 0, 50, 100));
    send_beat(make_beat(OP_DARK, 700, 500, 900));
    // Zero lit center blocks the update.
    send_beat(make_beat(OP_LIT, 100, 0, 100));
    send_beat(make_beat(OP_DARK, 200, 600, 200));
    // Dark center equal to the gate fails, one above passes.
    send_beat(make_beat(OP_LIT, 100, 10, 100));
    send_beat(make_beat(OP_DARK, 120, 300, 120));
    send_beat(make_beat(OP_DARK, 120, 301, 120));
    // Differences equal to the high thresholds keep black, one above flips white.
    send_beat(make_beat(OP_LIT, 100, 100, 100));
    send_beat(make_beat(OP_DARK, 750, 500, 750));
    send_beat(make_beat(OP_DARK, 751, 501, 751));
    // Differences equal to the low thresholds keep white.
    send_beat(make_beat(OP_DARK, 550, 450, 550));
    // Negative center difference blocks; negative outer differences go black.
    send_beat(make_beat(OP_LIT, 500, 900, 500));
    send_beat(make_beat(OP_DARK, 400, 800, 400));
    send_beat(make_beat(OP_LIT, 900, 100, 900));
    send_beat(make_beat(OP_DARK, 100, 600, 100));
    wait_for_drain();
  endtask

  // The receiver holds off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    idle_en = 1'b0;
    hold_left = 60;
    repeat (20) send_reading_pair();
    wait_for_drain();
    idle_en = 1'b1;
  endtask

  // Several threshold settings, extremes first, each with random traffic.
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_thresholds(0, 0, 0, 0, 0);
        1: write_thresholds(1023, 1023, 1023, 1023, 0);
        2: write_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                            pick_threshold(), 1023);
        3: write_thresholds(int'(CENTER_LOW_RESET), int'(CENTER_HIGH_RESET),
                            int'(CORNER_LOW_RESET), int'(CORNER_HIGH_RESET),
                            int'(DARK_GATE_RESET));
        default: write_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                                  pick_threshold(), $urandom_range(0, 600));
      endcase
      idle_en = (phase % 3 != 2);
      repeat (100) begin
        if ($urandom_range(0, 9) == 0) send_noise_beat();
        else send_reading_pair();
      end
      wait_for_drain();
    end
    idle_en = 1'b1;
  endtask

  // Back-to-back lit and dark beats with zero readings step both error counters.
  task automatic test_zero_readings();
    idle_en = 1'b0;
    repeat (40) begin
      send_beat(make_beat(OP_LIT, 0, $urandom_range(0, 1023), $urandom_range(0, 1023)));
      send_beat(make_beat(OP_DARK, $urandom_range(0, 1023), $urandom_range(0, 1023), 0));
    end
    idle_en = 1'b1;
    repeat (10) send_noise_beat();
    wait_for_drain();
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_data  = '0;
    sensor_cfg.center_low  = CENTER_LOW_RESET;
    sensor_cfg.center_high = CENTER_HIGH_RESET;
    sensor_cfg.corner_low  = CORNER_LOW_RESET;
    sensor_cfg.corner_high = CORNER_HIGH_RESET;
    sensor_cfg.dark_gate   = DARK_GATE_RESET;
    stored_left     = '0;
    stored_center   = '0;
    stored_right    = '0;
    tape_state      = 3'b000;
    lit_zero_count  = '0;
    dark_zero_count = '0;
    led_on          = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_random_phases();
    test_zero_readings();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
